/* sv/time_of_day_record_sorter_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the time of day record sorter
// Shared property forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_RECORD_SORTER_TOP_MACROS_SVH
`define TIME_OF_DAY_RECORD_SORTER_TOP_MACROS_SVH

// Same-cycle implication
`define TDRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tdrs: same-cycle check failed");

// Next-cycle implication
`define TDRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdrs: next-cycle check failed");

`endif

/* sv/tdrs_pkg.sv */
// ----------------------------------------------------------------------------
// Time of day record sorter package
// Record and key types, cell control struct, controller states, key function.
// ----------------------------------------------------------------------------
`default_nettype none

package tdrs_pkg;

  localparam int unsigned HourW = 5;
  localparam int unsigned MinW  = 6;
  localparam int unsigned TagW  = 16;
  localparam int unsigned KeyW  = 11;  // 31*60+63 = 1923 fits

  typedef logic [KeyW-1:0] key_t;

  typedef struct packed {
    logic [HourW-1:0] s_hour;
    logic [MinW-1:0]  s_min;
    logic [HourW-1:0] e_hour;
    logic [MinW-1:0]  e_min;
    logic [TagW-1:0]  tag;
  } rec_t;

  typedef struct packed {
    logic load;   // insert the broadcast request
    logic shift;  // move every record one cell towards the output
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  // Start time in minutes: hour*60 + minute, as hour*64 - hour*4 + minute
  function automatic key_t key_of(input logic [HourW-1:0] hour,
                                  input logic [MinW-1:0] minute);
    key_t h;
    h = KeyW'(hour);
    return (h << 6) - (h << 2) + KeyW'(minute);
  endfunction

endpackage

`default_nettype wire

/* sv/tdrs_cell.sv */
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one record and its key; makes room for a smaller incoming record
// by taking its left neighbour, and shifts left while the list drains.
// ----------------------------------------------------------------------------
`default_nettype none

module tdrs_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tdrs_pkg::cell_ctrl_t ctrl_i,
  input  tdrs_pkg::rec_t       new_rec_i,
  input  tdrs_pkg::key_t       new_key_i,
  input  wire                  left_gt_i,
  input  tdrs_pkg::rec_t       left_rec_i,
  input  tdrs_pkg::key_t       left_key_i,
  input  wire                  left_valid_i,
  input  tdrs_pkg::rec_t       right_rec_i,
  input  tdrs_pkg::key_t       right_key_i,
  input  wire                  right_valid_i,
  output logic                 gt_o,
  output tdrs_pkg::rec_t       rec_o,
  output tdrs_pkg::key_t       key_o,
  output logic                 valid_o
);
  import tdrs_pkg::*;

  rec_t rec_q, rec_d;
  key_t key_q, key_d;
  logic valid_q, valid_d;

  // Strict compare: an equal key stays ahead of the newcomer
  assign gt_o = !valid_q || (key_q > new_key_i);

  // Select the next content of the cell
  always_comb begin
    rec_d   = rec_q;
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      rec_d   = right_rec_i;
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.load && gt_o) begin
      if (left_gt_i) begin
        rec_d   = left_rec_i;
        key_d   = left_key_i;
        valid_d = left_valid_i;
      end else begin
        rec_d   = new_rec_i;
        key_d   = new_key_i;
        valid_d = 1'b1;
      end
    end
  end

  // Hold the valid flag; reset clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    key_q <= key_d;
  end

  assign rec_o   = rec_q;
  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

/* sv/time_of_day_record_sorter_top.sv */
// A list of n records loads at one request per cycle; the first
// sorted result shows in the cycle after the closing request is accepted.
// Results then drain while out_stall_i is low. The single chain of sorting
// cells both inserts and drains: the next list loads after the last result.
// Reset clears the cell valid flags, the controller state and overflow.
// ----------------------------------------------------------------------------
// Time of day record sorter, top level
// Stable insertion sort of one list by start time in a chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module time_of_day_record_sorter_top #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [4:0] start_hour_i,
  input  wire  [5:0] start_minute_i,
  input  wire  [4:0] end_hour_i,
  input  wire  [5:0] end_minute_i,
  input  wire [15:0] record_tag_i,
  input  wire        last_in_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [4:0] sorted_start_hour_o,
  output logic [5:0] sorted_start_minute_o,
  output logic [4:0] sorted_end_hour_o,
  output logic [5:0] sorted_end_minute_o,
  output logic [15:0] sorted_tag_o,
  output logic       last_out_o,
  output logic       overflow_o
);
  import tdrs_pkg::*;

  state_e     state_q, state_d;
  logic       overflow_q, overflow_d;
  cell_ctrl_t ctrl;
  rec_t       new_rec;
  key_t       new_key;
  logic       in_acc, out_acc, full;

  rec_t rec_w   [MAX_RECORDS];
  key_t key_w   [MAX_RECORDS];
  logic valid_w [MAX_RECORDS];
  logic gt_w    [MAX_RECORDS];

  // Form the incoming record and its key
  always_comb begin
    new_rec.s_hour = start_hour_i;
    new_rec.s_min  = start_minute_i;
    new_rec.e_hour = end_hour_i;
    new_rec.e_min  = end_minute_i;
    new_rec.tag    = record_tag_i;
    new_key        = key_of(start_hour_i, start_minute_i);
  end

  assign full    = valid_w[MAX_RECORDS-1];
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  if (in_acc && last_in_i) state_d = ST_DRAIN;
      ST_DRAIN: if (out_acc && last_out_o) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.shift  = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        ctrl.load  = in_acc && !full;
      end
      ST_DRAIN: begin
        out_valid_o = 1'b1;
        ctrl.shift  = out_acc;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Flag a dropped request until the list has drained
  always_comb begin
    overflow_d = overflow_q;
    if (in_acc && full) begin
      overflow_d = 1'b1;
    end else if (out_acc && last_out_o) begin
      overflow_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      overflow_q <= overflow_d;
    end
  end

  // Chain of sorting cells, cell 0 faces the output
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic lgt, lval, rval;
    rec_t lrec, rrec;
    key_t lkey, rkey;

    if (i == 0) begin : g_first
      assign lgt  = 1'b0;
      assign lrec = new_rec;
      assign lkey = new_key;
      assign lval = 1'b0;
    end else begin : g_inner
      assign lgt  = gt_w[i-1];
      assign lrec = rec_w[i-1];
      assign lkey = key_w[i-1];
      assign lval = valid_w[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_last
      assign rrec = new_rec;
      assign rkey = new_key;
      assign rval = 1'b0;
    end else begin : g_mid
      assign rrec = rec_w[i+1];
      assign rkey = key_w[i+1];
      assign rval = valid_w[i+1];
    end

    tdrs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_rec_i    (new_rec),
      .new_key_i    (new_key),
      .left_gt_i    (lgt),
      .left_rec_i   (lrec),
      .left_key_i   (lkey),
      .left_valid_i (lval),
      .right_rec_i  (rrec),
      .right_key_i  (rkey),
      .right_valid_i(rval),
      .gt_o         (gt_w[i]),
      .rec_o        (rec_w[i]),
      .key_o        (key_w[i]),
      .valid_o      (valid_w[i])
    );
  end

  // Present the head of the chain
  assign sorted_start_hour_o   = rec_w[0].s_hour;
  assign sorted_start_minute_o = rec_w[0].s_min;
  assign sorted_end_hour_o     = rec_w[0].e_hour;
  assign sorted_end_minute_o   = rec_w[0].e_min;
  assign sorted_tag_o          = rec_w[0].tag;
  assign last_out_o            = !valid_w[1];
  assign overflow_o            = overflow_q;

endmodule

`default_nettype wire

/* sv/tdrs_checker.sv */
// ----------------------------------------------------------------------------
// Time of day record sorter port checker
// Watches load and drain phases as seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "time_of_day_record_sorter_top_macros.svh"

module tdrs_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        last_in_i,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire        last_out_o,
  input wire        overflow_o
);

  // No request is taken while a list drains
  `TDRS_ASSERT_IMP(a_stall_in_drain, out_valid_o, in_stall_o)

  // A closing request starts the drain at once
  `TDRS_ASSERT_NXT(a_close_drains, in_valid_i && !in_stall_o && last_in_i, out_valid_o)

  // The final result ends the drain
  `TDRS_ASSERT_NXT(a_last_ends, out_valid_o && !out_stall_i && last_out_o, !out_valid_o)

  // Overflow stays the same over all results of one list
  `TDRS_ASSERT_NXT(a_ovf_steady, out_valid_o && !out_stall_i && !last_out_o,
                   overflow_o == $past(overflow_o))

endmodule

bind time_of_day_record_sorter_top tdrs_checker u_tdrs_checker (.*);

`default_nettype wire
